### src/sst_pkg.sv
`timescale 1ns / 1ps
package sst_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	// Command codes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_CMP,
		ST_INS_SH,
		ST_INS_PUT,
		ST_DEL_SH,
		ST_RESP
	} state_t;

endpackage

### src/sst_mem.sv
`timescale 1ns / 1ps
module sst_mem
	import sst_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/sorted_set_table.sv
`timescale 1ns / 1ps
// Channel  | Signals                          | Direction
// ---------+----------------------------------+----------
// in       | in_valid, in_ready, opcode, value | into block
// out      | out_valid, out_ready, ok,         | out of block
//          | full_res, count                  |
//
// One command at a time. Find runs a binary search of S steps, S at most
// ceil(log2(used+1)), one RAM read and compare per step.
// A new insert shifts entries p..used-1 up when p < used, none at p = used;
// delete shifts p+1..used-1 down, p = sorted position: shifting moves one
// entry a cycle through the RAM. Clear empties the table without a search.
// arst_n clears used_q and control; table and result data stay undefined.
// A result waiting on out_ready holds the next command in the reply state.
module sorted_set_table
	import sst_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     ok,
	output logic                     full_res,
	output logic [COUNT_W-1:0]       count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int UW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;
	op_t op_q, op_d;
	logic signed [DATA_W-1:0] val_q, val_d;
	logic [UW-1:0] lo_q, lo_d, hi_q, hi_d, used_q, used_d;
	logic fnd_q, fnd_d;
	logic [AW-1:0] idx_q, idx_d;
	logic rok_q, rok_d, rfull_q, rfull_d;
	logic out_valid_q, ok_q, full_q;
	logic [COUNT_W-1:0] count_q;
	logic res_load;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	logic [UW:0]      lohi_sum;
	logic [UW-1:0]    mid;
	logic [AW-1:0]    pos;
	logic [UW-1:0]    used_m1;
	logic [UW+4:0]    used_ext;

	sst_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Search midpoint and sorted position
	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = UW'(lohi_sum >> 1);
	assign pos      = AW'(lo_q);
	assign used_m1  = used_q - UW'(1);
	assign used_ext = (UW+5)'(used_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign full_res  = full_q;
	assign count     = count_q;

	// Next state, RAM control
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		val_d     = val_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		fnd_d     = fnd_q;
		idx_d     = idx_q;
		used_d    = used_q;
		rok_d     = rok_q;
		rfull_d   = rfull_q;
		res_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_d    = op_t'(opcode);
					val_d   = value;
					lo_d    = '0;
					hi_d    = used_q;
					fnd_d   = 1'b0;
					rok_d   = 1'b0;
					rfull_d = 1'b0;
					state_d = ST_SRCH;
					if (op_t'(opcode) == OP_CLEAR) begin
						used_d  = '0;
						rok_d   = 1'b1;
						state_d = ST_RESP;
					end
				end
			end
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(mid);
					state_d   = ST_CMP;
				end else begin
					state_d = ST_RESP;
					case (op_q)
						OP_FIND: begin
							rok_d = fnd_q;
						end
						OP_INSERT: begin
							if (fnd_q) begin
								rok_d = 1'b0;
							end else if (used_q == UW'(CAPACITY)) begin
								rfull_d = 1'b1;
							end else if (lo_q == used_q) begin
								mem_we    = 1'b1;
								mem_waddr = pos;
								mem_wdata = val_q;
								used_d    = used_q + UW'(1);
								rok_d     = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(used_m1);
								idx_d     = AW'(used_m1);
								state_d   = ST_INS_SH;
							end
						end
						OP_DELETE: begin
							if (fnd_q) begin
								if (lo_q == used_m1) begin
									used_d = used_m1;
									rok_d  = 1'b1;
								end else begin
									mem_re    = 1'b1;
									mem_raddr = pos + AW'(1);
									idx_d     = pos + AW'(1);
									state_d   = ST_DEL_SH;
								end
							end
						end
						default: begin
							rok_d = 1'b1;
						end
					endcase
				end
			end
			ST_CMP: begin
				// Lower-bound step; remember equality on every upper move
				if ($signed(mem_rdata) < val_q) begin
					lo_d = mid + UW'(1);
				end else begin
					hi_d  = mid;
					fnd_d = ($signed(mem_rdata) == val_q);
				end
				state_d = ST_SRCH;
			end
			ST_INS_SH: begin
				// Move entry idx up by one; read the next lower entry
				mem_we    = 1'b1;
				mem_waddr = idx_q + AW'(1);
				mem_wdata = mem_rdata;
				if (idx_q == pos) begin
					state_d = ST_INS_PUT;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q - AW'(1);
					idx_d     = idx_q - AW'(1);
				end
			end
			ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos;
				mem_wdata = val_q;
				used_d    = used_q + UW'(1);
				rok_d     = 1'b1;
				state_d   = ST_RESP;
			end
			ST_DEL_SH: begin
				// Move entry idx down by one; read the next higher entry
				mem_we    = 1'b1;
				mem_waddr = idx_q - AW'(1);
				mem_wdata = mem_rdata;
				if (UW'(idx_q) == used_m1) begin
					used_d  = used_m1;
					rok_d   = 1'b1;
					state_d = ST_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q + AW'(1);
					idx_d     = idx_q + AW'(1);
				end
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command and result payload
	always_ff @(posedge clk) begin
		op_q    <= op_d;
		val_q   <= val_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		fnd_q   <= fnd_d;
		idx_q   <= idx_d;
		rok_q   <= rok_d;
		rfull_q <= rfull_d;
		if (res_load) begin
			ok_q    <= rok_q;
			full_q  <= rfull_q;
			count_q <= used_ext[COUNT_W-1:0];
		end
	end

	// Checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(CAPACITY))
		else $error("stored count exceeds capacity");

	a_ok_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(ok_q && full_q))
		else $error("ok and full_res both set");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && full_q) |-> (count_q == COUNT_W'(CAPACITY)))
		else $error("insert refused with table not full");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (lo_q < hi_q && hi_q <= used_q))
		else $error("search bounds out of order");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("transfer accepted without starting work");

endmodule
